>>> sv/length_prefixed_command_deframer_assert.svh
// Assertion macros for the length-prefixed command deframer.
// Used by the top level only; no other dependencies.
`ifndef LENGTH_PREFIXED_COMMAND_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_COMMAND_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LPCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpcd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpcd next-cycle check failed");

`endif

>>> sv/lpcd_pkg.sv
// Shared types and constants for the length-prefixed command deframer.
// No dependencies.
package lpcd_pkg;

  localparam int unsigned MaxPayloadDefault = 60;
  localparam int unsigned HdrLen            = 4;
  localparam int unsigned CmdLen            = 8;
  localparam int unsigned LenW              = 6;
  localparam logic [7:0]  CmdTypeReset      = 8'd1;

  typedef struct packed {
    logic [15:0]        packet_number;
    logic [7:0]         packet_type;
    logic [LenW-1:0]    payload_length;
    logic               is_command;
    logic               target_slot;
    logic               active_slot;
    logic signed [15:0] gimbal_x;
    logic signed [15:0] gimbal_y;
    logic [7:0]         motor0_speed;
    logic [7:0]         motor1_speed;
  } lpcd_result_t;

  typedef struct packed {
    logic            in_payload;
    logic [LenW-1:0] byte_count;
    logic [LenW-1:0] payload_len;
  } lpcd_status_t;

endpackage

>>> sv/length_prefixed_command_deframer.sv
// Top level of the length-prefixed command deframer.
// Depends on lpcd_pkg, lpcd_parser, lpcd_out_buf and the assertion header.
//
// Usage: received bytes enter one request at a time on in_rx_byte with
// in_valid/in_ready. Each packet is a 4-byte header (packet number low and
// high, type, length) followed by min(length, MAX_PAYLOAD) payload bytes.
// When a packet completes (on its last payload byte, or on the header's
// length byte when the clamped length is zero) one result request appears
// on the out_ channel with out_valid/out_ready.
// Each result is registered, in the skid register while another waits.
// Throughput: one byte per cycle while in_ready is high.
// A result register plus one skid register let a byte be taken while a
// result waits; in_ready drops only when both hold results, and rises
// again as soon as the receiver takes one.
// The command type code is written through cfg_valid/cfg_ready (always
// high); the user must write it only while idle; the block does no check.
// Reset (synchronous, rst_n low) returns to header capture, clears the
// eight-byte command store and sets the command type code to 1.
module length_prefixed_command_deframer
  import lpcd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_command_type_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_packet_number,
  output logic [7:0]          out_packet_type,
  output logic [LenW-1:0]     out_payload_length,
  output logic                out_is_command,
  output logic                out_target_slot,
  output logic                out_active_slot,
  output logic signed [15:0]  out_gimbal_x,
  output logic signed [15:0]  out_gimbal_y,
  output logic [7:0]          out_motor0_speed,
  output logic [7:0]          out_motor1_speed
);

`include "length_prefixed_command_deframer_assert.svh"

  logic         in_fire;
  logic         res_valid;
  lpcd_result_t res;
  lpcd_result_t out_data;
  lpcd_status_t status;
  logic [7:0]   cmd_type_r;

  // The configuration register accepts a write every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_type_r <= CmdTypeReset;
    end else if (cfg_valid) begin
      cmd_type_r <= cfg_command_type_code;
    end
  end

  assign in_fire = in_valid && in_ready;

  lpcd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .byte_valid       (in_fire),
    .rx_byte          (in_rx_byte),
    .command_type_code(cmd_type_r),
    .res_valid        (res_valid),
    .res              (res),
    .status           (status)
  );

  lpcd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(res_valid),
    .push_data (res),
    .space     (in_ready),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (out_data)
  );

  assign out_packet_number  = out_data.packet_number;
  assign out_packet_type    = out_data.packet_type;
  assign out_payload_length = out_data.payload_length;
  assign out_is_command     = out_data.is_command;
  assign out_target_slot    = out_data.target_slot;
  assign out_active_slot    = out_data.active_slot;
  assign out_gimbal_x       = out_data.gimbal_x;
  assign out_gimbal_y       = out_data.gimbal_y;
  assign out_motor0_speed   = out_data.motor0_speed;
  assign out_motor1_speed   = out_data.motor1_speed;

  // A completed packet must be held in the output or skid register.
  `LPCD_ASSERT_NEXT(a_result_lands, clk, rst_n, in_fire && res_valid, out_valid)
  // Input is held off only when the output side holds a pending result.
  `LPCD_ASSERT_NOW(a_stall_has_result, clk, rst_n, !in_ready, out_valid)
  // Header capture never counts past the fourth byte.
  `LPCD_ASSERT_NOW(a_hdr_count, clk, rst_n, !status.in_payload,
                   status.byte_count < LenW'(HdrLen))
  // In the payload the count stays below the clamped length.
  `LPCD_ASSERT_NOW(a_pay_count, clk, rst_n, status.in_payload,
                   (status.byte_count < status.payload_len) &&
                   (status.payload_len <= LenW'(MAX_PAYLOAD)))

endmodule

>>> sv/lpcd_parser.sv
// Framing state machine of the deframer: header capture, payload count,
// command store and result decode. Depends on lpcd_pkg.
module lpcd_parser
  import lpcd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         byte_valid,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   command_type_code,
  output logic         res_valid,
  output lpcd_result_t res,
  output lpcd_status_t status
);

  localparam logic [7:0]      MaxByte = 8'(MAX_PAYLOAD);
  localparam logic [LenW-1:0] MaxLen  = LenW'(MAX_PAYLOAD);

  logic                   in_payload_r, in_payload_nxt;
  logic [LenW-1:0]        count_r, count_nxt;
  logic [7:0]             hdr_r [3];
  logic [LenW-1:0]        len_r, len_nxt;
  logic [7:0]             cmd_r [CmdLen];
  logic [7:0]             cmd_nxt [CmdLen];
  logic [LenW-1:0]        clamped_len;
  logic [LenW-1:0]        count_inc;

  assign clamped_len = (rx_byte > MaxByte) ? MaxLen : rx_byte[LenW-1:0];
  assign count_inc   = count_r + LenW'(1);

  always_comb begin
    in_payload_nxt = in_payload_r;
    count_nxt      = count_r;
    len_nxt        = len_r;
    res_valid      = 1'b0;
    for (int i = 0; i < CmdLen; i++) begin
      cmd_nxt[i] = cmd_r[i];
    end
    if (byte_valid) begin
      if (!in_payload_r) begin
        if (count_r == LenW'(HdrLen - 1)) begin
          count_nxt = '0;
          len_nxt   = clamped_len;
          if (clamped_len == '0) begin
            res_valid = 1'b1;
          end else begin
            in_payload_nxt = 1'b1;
          end
        end else begin
          count_nxt = count_inc;
        end
      end else begin
        if (count_r < LenW'(CmdLen)) begin
          cmd_nxt[count_r[$clog2(CmdLen)-1:0]] = rx_byte;
        end
        if (count_inc >= len_r) begin
          count_nxt      = '0;
          in_payload_nxt = 1'b0;
          res_valid      = 1'b1;
        end else begin
          count_nxt = count_inc;
        end
      end
    end
  end

  // Decode from the store as it stands after this byte.
  always_comb begin
    res                = '0;
    res.packet_number  = {hdr_r[1], hdr_r[0]};
    res.packet_type    = hdr_r[2];
    res.payload_length = len_nxt;
    res.is_command     = (hdr_r[2] == command_type_code);
    if (res.is_command) begin
      res.target_slot  = cmd_nxt[0][0];
      res.active_slot  = cmd_nxt[0][1];
      res.gimbal_x     = {cmd_nxt[2], cmd_nxt[1]};
      res.gimbal_y     = {cmd_nxt[4], cmd_nxt[3]};
      res.motor0_speed = cmd_nxt[5];
      res.motor1_speed = cmd_nxt[6];
    end
  end

  assign status.in_payload  = in_payload_r;
  assign status.byte_count  = count_r;
  assign status.payload_len = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      count_r      <= '0;
      len_r        <= '0;
      for (int i = 0; i < CmdLen; i++) begin
        cmd_r[i] <= '0;
      end
    end else begin
      in_payload_r <= in_payload_nxt;
      count_r      <= count_nxt;
      len_r        <= len_nxt;
      for (int i = 0; i < CmdLen; i++) begin
        cmd_r[i] <= cmd_nxt[i];
      end
    end
  end

  // Header bytes are always rewritten before they are used.
  always_ff @(posedge clk) begin
    if (byte_valid && !in_payload_r && (count_r < LenW'(HdrLen - 1))) begin
      hdr_r[count_r[1:0]] <= rx_byte;
    end
  end

endmodule

>>> sv/lpcd_out_buf.sv
// Result register with a skid stage for the deframer output channel.
// Depends on lpcd_pkg.
module lpcd_out_buf
  import lpcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  input  lpcd_result_t push_data,
  output logic         space,
  output logic         pop_valid,
  input  logic         pop_ready,
  output lpcd_result_t pop_data
);

  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  lpcd_result_t main_r, main_nxt;
  lpcd_result_t skid_r, skid_nxt;
  logic         pop_fire;

  assign space     = !skid_valid_r;
  assign pop_valid = main_valid_r;
  assign pop_data  = main_r;
  assign pop_fire  = main_valid_r && pop_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop_fire) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!main_valid_r || pop_fire) begin
      main_valid_nxt = push_valid;
      if (push_valid) begin
        main_nxt = push_data;
      end
    end else if (push_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
